FILE: rtl/core/page_entry_table_dirty_tracker_unit_assert.svh
// assertion macros for the tracker's checker file
`ifndef PAGE_ENTRY_TABLE_DIRTY_TRACKER_UNIT_ASSERT_SVH
`define PAGE_ENTRY_TABLE_DIRTY_TRACKER_UNIT_ASSERT_SVH

// clocked property, switched off while reset is low
`define PEDT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pedt check failed");

// clocked property that also holds through reset
`define PEDT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("pedt check failed");

`endif

FILE: rtl/core/pedt_pkg.sv
// shared constants, opcodes and types of the page entry table dirty tracker
package pedt_pkg;

    // field widths
    localparam int PAGE_BITS   = 20;
    localparam int PROC_BITS   = 4;
    localparam int OP_BITS     = 2;
    localparam int CNT_W       = 6;
    localparam int ENTRIES_DEF = 32;

    // opcodes
    localparam logic [OP_BITS-1:0] OP_ACCESS     = 2'd0;
    localparam logic [OP_BITS-1:0] OP_FLUSH_ALL  = 2'd1;
    localparam logic [OP_BITS-1:0] OP_FLUSH_PROC = 2'd2;

    // input beat layout, lowest bit first
    localparam int IN_OP_LSB   = 0;
    localparam int IN_PAGE_LSB = IN_OP_LSB + OP_BITS;
    localparam int IN_PROC_LSB = IN_PAGE_LSB + PAGE_BITS;
    localparam int IN_WR_LSB   = IN_PROC_LSB + PROC_BITS;
    localparam int IN_FIELD_W  = IN_WR_LSB + 1;
    localparam int IN_TDATA_W  = ((IN_FIELD_W + 7) / 8) * 8;

    // output beat layout, lowest bit first
    localparam int OUT_NEW_LSB   = 0;
    localparam int OUT_DROP_LSB  = 1;
    localparam int OUT_REM_LSB   = 2;
    localparam int OUT_DIRTY_LSB = OUT_REM_LSB + CNT_W;
    localparam int OUT_FIELD_W   = OUT_DIRTY_LSB + CNT_W;
    localparam int OUT_TDATA_W   = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W     = OUT_TDATA_W - OUT_FIELD_W;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

endpackage

FILE: rtl/core/page_entry_table_dirty_tracker_unit.sv
// page entry table with dirty tracking, scanned one entry per cycle
//
// Table of up to ENTRIES resident pages, each keyed by (page number, process)
// and carrying a dirty mark. Every input beat is one command: an access looks
// the pair up (a write hit sets dirty, a miss takes the lowest free slot and
// reports new_entry, a miss on a full table is dropped and reports
// table_full_drop), a flush-all empties the table and a flush-by-process
// removes that process's entries; flushes report how many entries went and
// how many of them were dirty (both counts wrap at 64). Opcode 3 is a no-op
// whose result is all zero. Exactly one result beat comes out per input beat.
// Timing: the entry store has one read port and the sequencer walks it one
// entry per cycle: after a command is accepted it scans every entry, drains
// the registered read, then updates the table and loads the result register.
// The next command is accepted only once the sequencer is back in idle, so a
// new command is not taken while the previous one is still being worked on.
// o_s_tready is high only while the sequencer is idle; the result sits in an
// output register, so the next command is accepted while it waits, and a
// command only stalls in its last cycle if the previous result is still
// untaken. Valid bits clear at reset; no clearing pass is needed.
module page_entry_table_dirty_tracker_unit #(
    parameter int ENTRIES = pedt_pkg::ENTRIES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // command side
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // opcode, page_number, process_id, is_write, zero pad
    input  logic [pedt_pkg::IN_TDATA_W-1:0] i_s_tdata,
    // result side
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // new_entry, table_full_drop, removed_count, dirty_count, zero pad
    output logic [pedt_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int PB = pedt_pkg::PAGE_BITS;
    localparam int QB = pedt_pkg::PROC_BITS;
    localparam int CW = pedt_pkg::CNT_W;

    // sequencer
    pedt_pkg::t_state r_state, n_state;
    logic accept;
    logic scan_en;
    logic done_fire;

    // latched command
    logic [pedt_pkg::OP_BITS-1:0] r_op;
    logic [PB-1:0]                r_page;
    logic [QB-1:0]                r_proc;
    logic                         r_wr;

    // scan pointer and registered read stage
    logic [IW-1:0] r_idx;
    logic [IW-1:0] r_rd_idx;
    logic          r_rd_live;
    logic          r_rd_valid;
    logic [PB-1:0] r_rd_page;
    logic [QB-1:0] r_rd_owner;
    logic          r_rd_dirty;

    // entry store: valid bits in flops, payload in memory
    logic [ENTRIES-1:0] r_valid;
    logic [PB-1:0]      mem_page  [ENTRIES];
    logic [QB-1:0]      mem_owner [ENTRIES];
    logic               mem_dirty [ENTRIES];

    // scan results
    logic          r_hit_found;
    logic [IW-1:0] r_hit_idx;
    logic          r_free_found;
    logic [IW-1:0] r_free_idx;
    logic [CW-1:0] r_removed;
    logic [CW-1:0] r_dirties;

    // compare stage
    logic rd_match;
    logic flush_hit;
    logic is_access;
    logic do_add;
    logic do_drop;

    // result register
    logic                               r_out_valid;
    logic [pedt_pkg::OUT_FIELD_W-1:0]   r_out_fields;

    assign accept = i_s_tvalid && o_s_tready;

    // ---------------- sequencer: next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pedt_pkg::ST_IDLE: begin
                if (i_s_tvalid) n_state = pedt_pkg::ST_SCAN;
            end
            pedt_pkg::ST_SCAN: begin
                if (r_idx == IW'(ENTRIES - 1)) n_state = pedt_pkg::ST_DRAIN;
            end
            pedt_pkg::ST_DRAIN: begin
                n_state = pedt_pkg::ST_DONE;
            end
            pedt_pkg::ST_DONE: begin
                if (!r_out_valid || i_m_tready) n_state = pedt_pkg::ST_IDLE;
            end
            default: n_state = pedt_pkg::ST_IDLE;
        endcase
    end

    // ---------------- sequencer: outputs ----------------
    always_comb begin
        o_s_tready = 1'b0;
        scan_en    = 1'b0;
        done_fire  = 1'b0;
        unique case (r_state)
            pedt_pkg::ST_IDLE:  o_s_tready = 1'b1;
            pedt_pkg::ST_SCAN:  scan_en    = 1'b1;
            pedt_pkg::ST_DRAIN: ;
            pedt_pkg::ST_DONE:  done_fire  = !r_out_valid || i_m_tready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pedt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // command latch
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_s_tdata[pedt_pkg::IN_OP_LSB +: pedt_pkg::OP_BITS];
            r_page <= i_s_tdata[pedt_pkg::IN_PAGE_LSB +: PB];
            r_proc <= i_s_tdata[pedt_pkg::IN_PROC_LSB +: QB];
            r_wr   <= i_s_tdata[pedt_pkg::IN_WR_LSB];
        end
    end

    // ---------------- compare stage ----------------
    assign rd_match  = (r_rd_page == r_page) && (r_rd_owner == r_proc);
    assign flush_hit = r_rd_valid &&
                       ((r_op == pedt_pkg::OP_FLUSH_ALL) ||
                        ((r_op == pedt_pkg::OP_FLUSH_PROC) && (r_rd_owner == r_proc)));
    assign is_access = (r_op == pedt_pkg::OP_ACCESS);
    assign do_add    = is_access && !r_hit_found && r_free_found;
    assign do_drop   = is_access && !r_hit_found && !r_free_found;

    // scan pointer, read pipeline flag and running results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx        <= '0;
            r_rd_live    <= 1'b0;
            r_hit_found  <= 1'b0;
            r_free_found <= 1'b0;
            r_removed    <= '0;
            r_dirties    <= '0;
        end else begin
            r_rd_live <= scan_en;
            if (accept) begin
                r_idx        <= '0;
                r_hit_found  <= 1'b0;
                r_free_found <= 1'b0;
                r_removed    <= '0;
                r_dirties    <= '0;
            end else begin
                if (scan_en) r_idx <= r_idx + 1'b1;
                if (r_rd_live) begin
                    // first matching valid entry wins
                    if (is_access && r_rd_valid && rd_match && !r_hit_found) begin
                        r_hit_found <= 1'b1;
                    end
                    // lowest free slot
                    if (is_access && !r_rd_valid && !r_free_found) begin
                        r_free_found <= 1'b1;
                    end
                    if (flush_hit) begin
                        r_removed <= r_removed + 1'b1;
                        if (r_rd_dirty) r_dirties <= r_dirties + 1'b1;
                    end
                end
            end
        end
    end

    // slot indexes ride along with the found flags
    always_ff @(posedge i_clk) begin
        if (r_rd_live && is_access) begin
            if (r_rd_valid && rd_match && !r_hit_found) r_hit_idx <= r_rd_idx;
            if (!r_rd_valid && !r_free_found)          r_free_idx <= r_rd_idx;
        end
    end

    // valid bits: cleared by a flush in the compare stage, set on an add
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (r_rd_live && flush_hit) r_valid[r_rd_idx] <= 1'b0;
            if (done_fire && do_add)    r_valid[r_free_idx] <= 1'b1;
        end
    end

    // entry memory: one read port for the scan, writes in the update cycle
    always_ff @(posedge i_clk) begin
        r_rd_idx   <= r_idx;
        r_rd_valid <= r_valid[r_idx];
        r_rd_page  <= mem_page[r_idx];
        r_rd_owner <= mem_owner[r_idx];
        r_rd_dirty <= mem_dirty[r_idx];
        if (done_fire && do_add) begin
            mem_page[r_free_idx]  <= r_page;
            mem_owner[r_free_idx] <= r_proc;
            mem_dirty[r_free_idx] <= r_wr;
        end else if (done_fire && is_access && r_hit_found && r_wr) begin
            mem_dirty[r_hit_idx] <= 1'b1;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done_fire) begin
            r_out_fields <= {r_dirties, r_removed, do_drop, do_add};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{pedt_pkg::OUT_PAD_W{1'b0}}, r_out_fields};

endmodule

FILE: rtl/core/pedt_checker.sv
// port-level checker for the page entry table dirty tracker, with its bind
`include "page_entry_table_dirty_tracker_unit_assert.svh"

module pedt_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_tvalid,
    input logic                             o_s_tready,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [pedt_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    logic new_entry;
    logic full_drop;
    logic [2*pedt_pkg::CNT_W-1:0] counts;
    logic s_beat;

    assign new_entry = o_m_tdata[pedt_pkg::OUT_NEW_LSB];
    assign full_drop = o_m_tdata[pedt_pkg::OUT_DROP_LSB];
    assign counts    = o_m_tdata[pedt_pkg::OUT_REM_LSB +: 2*pedt_pkg::CNT_W];
    assign s_beat    = i_s_tvalid && o_s_tready;

    // a pending result stays until taken
    `PEDT_ASSERT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid)
    // a result never reports both new and dropped
    `PEDT_ASSERT(a_flags_excl, i_clk, i_rst_n, o_m_tvalid |-> !(new_entry && full_drop))
    // new or dropped access results carry no flush counts
    `PEDT_ASSERT(a_access_no_counts, i_clk, i_rst_n,
        o_m_tvalid && (new_entry || full_drop) |-> counts == '0)
    // the sequencer is busy right after a command beat and has no result yet
    `PEDT_ASSERT(a_busy_after_cmd, i_clk, i_rst_n,
        s_beat |=> !o_s_tready && !$rose(o_m_tvalid))
    // reset drops any pending result
    `PEDT_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_m_tvalid)

endmodule

bind page_entry_table_dirty_tracker_unit pedt_checker u_pedt_checker (.*);
